@@ rtl/otst_pkg.sv @@
// Shared types and constants for the one-shot timer task table.
// Request and result structs, mode codes, field widths. No dependencies.
package otst_pkg;

    localparam int HANDLE_W       = 8;
    localparam int COUNT_W        = 24;
    localparam int PERIOD_W       = 16;
    localparam int PRESCALE_W     = 8;
    localparam int MODE_W         = 2;
    localparam int SLOTS_DEF      = 8;
    localparam int ENTRY_W        = HANDLE_W + COUNT_W;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd7;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FETCH = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] task_handle;
        logic [PERIOD_W-1:0] period;
    } t_req;

    typedef struct packed {
        logic                add_ok;
        logic [HANDLE_W-1:0] ready_handle;
    } t_rsp;

    // Per-request context handed to the slot update logic
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  load;
        logic                done;
    } t_upd_ctl;

    // Outcome of updating one slot
    typedef struct packed {
        logic                we;
        logic [HANDLE_W-1:0] wr_handle;
        logic [COUNT_W-1:0]  wr_count;
        logic                claim;
        logic                add_ok;
        logic [HANDLE_W-1:0] ready_handle;
    } t_upd_res;

endpackage

@@ rtl/one_shot_timer_task_table_unit.sv @@
// One-shot timer task table: top level with slot walker and result register.
// Depends on otst_pkg, otst_ram, otst_slot_upd.
//
// Usage:
//   Requests enter on i_req (mode, task_handle, period) and are taken at a
//   clock edge with start high and busy low. Mode add places the handle in
//   the lowest free slot with count period * prescale; mode tick decrements
//   every running slot; mode fetch frees the lowest expired slot.
//   Each request gives exactly one result on o_rsp, marked by o_rsp_valid
//   for a single cycle; the receiver cannot stall it.
//   o_rsp_valid rises when the walk over the slot RAM has passed the last
//   slot, and busy falls with it, so a new request is taken only after the
//   last one is through. The walk handles one slot per cycle, read and
//   written back through the RAM's single read and write ports.
//   The user must write tick_prescale through i_cfg_we / i_cfg_wdata only
//   while idle; the block does not enforce it. Reset (synchronous, active
//   low) sets the prescale to 7 and clears the per-slot valid bits, so every
//   slot reads as free with count zero; no clearing pass is needed.
module one_shot_timer_task_table_unit #(
    parameter int SLOTS = otst_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  otst_pkg::t_req                    i_req,
    output logic                              o_rsp_valid,
    output otst_pkg::t_rsp                    o_rsp,
    input  logic                              i_cfg_we,
    input  logic [otst_pkg::PRESCALE_W-1:0]   i_cfg_wdata
);
    import otst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                  r_state;
    logic [PRESCALE_W-1:0] r_prescale;
    logic [MODE_W-1:0]     r_mode;
    logic [HANDLE_W-1:0]   r_handle;
    logic [COUNT_W-1:0]    r_load;
    logic                  r_done;
    logic                  r_add_ok;
    logic [HANDLE_W-1:0]   r_ready;
    logic [CW-1:0]         r_rd_cnt;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic [SLOTS-1:0]      r_valid;
    logic                  r_rsp_vld;
    t_rsp                  r_rsp;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_we;
    logic [HANDLE_W-1:0]   ent_handle;
    logic [COUNT_W-1:0]    ent_count;
    t_upd_ctl              upd_ctl;
    t_upd_res              upd_res;
    logic                  rd_issue;

    otst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_cnt[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // never-written slots read as free with zero count
    assign ent_handle = r_valid[r_rd_idx] ? ram_rdata[ENTRY_W-1 -: HANDLE_W] : '0;
    assign ent_count  = r_valid[r_rd_idx] ? ram_rdata[COUNT_W-1:0] : '0;

    always_comb begin
        upd_ctl.mode   = r_mode;
        upd_ctl.handle = r_handle;
        upd_ctl.load   = r_load;
        upd_ctl.done   = r_done;
    end

    otst_slot_upd u_upd (
        .i_ctl    (upd_ctl),
        .i_handle (ent_handle),
        .i_count  (ent_count),
        .o_res    (upd_res)
    );

    assign ram_we    = (r_state == ST_RUN) && r_rd_vld && upd_res.we;
    assign ram_wdata = {upd_res.wr_handle, upd_res.wr_count};
    assign rd_issue  = (r_rd_cnt < CW'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_prescale <= PRESCALE_RESET;
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_cnt   <= '0;
            r_rsp_vld  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_rsp_vld <= 1'b0;
            if (i_cfg_we) begin
                r_prescale <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_valid[r_rd_idx] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (start) begin
                        r_mode   <= i_req.mode;
                        r_handle <= i_req.task_handle;
                        r_load   <= COUNT_W'(i_req.period) * COUNT_W'(r_prescale);
                        r_done   <= 1'b0;
                        r_add_ok <= 1'b0;
                        r_ready  <= '0;
                        r_rd_cnt <= '0;
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rd_vld <= rd_issue;
                    r_rd_idx <= r_rd_cnt[IW-1:0];
                    if (rd_issue) begin
                        r_rd_cnt <= r_rd_cnt + CW'(1);
                    end
                    if (r_rd_vld) begin
                        if (upd_res.claim) begin
                            r_done <= 1'b1;
                        end
                        if (upd_res.add_ok) begin
                            r_add_ok <= 1'b1;
                        end
                        if (upd_res.ready_handle != '0) begin
                            r_ready <= upd_res.ready_handle;
                        end
                        if (r_rd_idx == LAST_IDX) begin
                            r_rsp.add_ok       <= r_add_ok | upd_res.add_ok;
                            r_rsp.ready_handle <= r_ready | upd_res.ready_handle;
                            r_rsp_vld          <= 1'b1;
                            r_state            <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state == ST_RUN);
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

endmodule

@@ rtl/otst_ram.sv @@
// Generic single write, single read port RAM with registered read data.
// No dependencies.
module otst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/otst_slot_upd.sv @@
// Read-modify-write decision for one timer slot: add, tick or fetch.
// Depends on otst_pkg.
module otst_slot_upd (
    input  otst_pkg::t_upd_ctl                  i_ctl,
    input  logic [otst_pkg::HANDLE_W-1:0]       i_handle,
    input  logic [otst_pkg::COUNT_W-1:0]        i_count,
    output otst_pkg::t_upd_res                  o_res
);
    import otst_pkg::*;

    logic occupied;

    assign occupied = (i_handle != '0);

    always_comb begin
        o_res              = '0;
        o_res.wr_handle    = i_handle;
        o_res.wr_count     = i_count;
        case (i_ctl.mode)
            MODE_ADD: begin
                // a zero handle still reports the free slot but stores nothing
                if (!i_ctl.done && !occupied) begin
                    o_res.claim  = 1'b1;
                    o_res.add_ok = 1'b1;
                    if (i_ctl.handle != '0) begin
                        o_res.we        = 1'b1;
                        o_res.wr_handle = i_ctl.handle;
                        o_res.wr_count  = i_ctl.load;
                    end
                end
            end
            MODE_TICK: begin
                if (occupied && (i_count != '0)) begin
                    o_res.we       = 1'b1;
                    o_res.wr_count = i_count - COUNT_W'(1);
                end
            end
            MODE_FETCH: begin
                // freed slot keeps its count until reloaded
                if (!i_ctl.done && occupied && (i_count == '0)) begin
                    o_res.claim        = 1'b1;
                    o_res.we           = 1'b1;
                    o_res.wr_handle    = '0;
                    o_res.ready_handle = i_handle;
                end
            end
            default: begin
                o_res.we = 1'b0;
            end
        endcase
    end

endmodule
